>>> design/tlas_pkg.sv
package tlas_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int LEVEL_W     = 8;
  localparam int RAW_W       = 10;
  localparam int CFG_ADDR_W  = 2;
  localparam int DIV_W       = 12;   // divisor / remainder width
  localparam int SH_W        = 16;   // dividend shift register / quotient width
  localparam int SCALED_W    = 22;   // raw * 4000
  localparam int PROD_W      = 20;   // (c - lo) * 255
  localparam int STEP_W      = 5;
  localparam int BOUND_SCALE = 4000;
  localparam int BOUND_DIV   = 1023;
  localparam int LEVEL_MAX   = 255;
  localparam int WINDOW_DEF  = 10;

  localparam int STEPS_BOUND = 12;
  localparam int STEPS_MEAN  = 16;
  localparam int STEPS_LVL   = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_A_LO = 2'd0,
    CFG_A_HI = 2'd1,
    CFG_D_LO = 2'd2,
    CFG_D_HI = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_RUN,
    ST_PREP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_LO,
    OP_HI,
    OP_MEAN,
    OP_LVL
  } op_t;

  typedef enum logic [1:0] {
    LV_ZERO,
    LV_FULL,
    LV_DIV
  } lvl_sel_t;

  typedef struct packed {
    logic accept;  // input transfer: capture sample, read oldest entry
    logic upd;     // update running sum, write history
    logic ld;      // load divider
    logic step;    // one divider iteration
    logic cap;     // capture quotient
    logic prep;    // clamp and form level dividend
    logic fin;     // move result to output register
    op_t  op;
  } ctl_t;

  function automatic logic [STEP_W-1:0] op_steps(op_t op);
    logic [STEP_W-1:0] n;
    case (op)
      OP_LO, OP_HI: n = STEP_W'(STEPS_BOUND);
      OP_MEAN:      n = STEP_W'(STEPS_MEAN);
      OP_LVL:       n = STEP_W'(STEPS_LVL);
      default:      n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> design/tlas_div.sv
module tlas_div (
  input  logic                        clk,
  input  logic                        ld,
  input  logic                        step,
  input  logic [tlas_pkg::DIV_W-1:0]  rem_init,
  input  logic [tlas_pkg::SH_W-1:0]   sh_init,
  input  logic [tlas_pkg::DIV_W-1:0]  divisor,
  output logic [tlas_pkg::SH_W-1:0]   quo
);
  import tlas_pkg::*;

  // restoring divider, one quotient bit per step, dividend shifted in MSB first
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]  sh_r, sh_nxt;
  logic [SH_W-1:0]  q_r, q_nxt;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, sh_r[SH_W-1]};
  assign ge    = (trial >= {1'b0, divisor});

  always_comb begin
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    q_nxt   = q_r;
    if (ld) begin
      rem_nxt = rem_init;
      sh_nxt  = sh_init;
      q_nxt   = '0;
    end else if (step) begin
      rem_nxt = ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      sh_nxt  = {sh_r[SH_W-2:0], 1'b0};
      q_nxt   = {q_r[SH_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
  end

  assign quo = q_r;

endmodule

>>> design/tlas_lane.sv
module tlas_lane #(
  parameter int WINDOW = tlas_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlas_pkg::ctl_t                ctl,
  input  logic [tlas_pkg::SAMPLE_W-1:0] sample,
  input  logic [tlas_pkg::RAW_W-1:0]    lo_raw,
  input  logic [tlas_pkg::RAW_W-1:0]    hi_raw,
  output logic [tlas_pkg::LEVEL_W-1:0]  level,
  output logic [tlas_pkg::SAMPLE_W-1:0] mean
);
  import tlas_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);

  // history memory; entries count as zero until the first wrap
  logic [SAMPLE_W-1:0] hist [WINDOW];
  logic [SAMPLE_W-1:0] rd_r;
  logic [SAMPLE_W-1:0] samp_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                full_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    old_val;

  assign old_val = full_r ? SUM_W'(rd_r) : '0;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      rd_r   <= hist[slot_r];
      samp_r <= sample;
    end
    if (ctl.upd) begin
      hist[slot_r] <= samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
    end else if (ctl.upd) begin
      sum_r <= sum_r + SUM_W'(samp_r) - old_val;
      if (slot_r == SLOT_W'(WINDOW - 1)) begin
        slot_r <= '0;
        full_r <= 1'b1;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // divider operand select
  logic [RAW_W-1:0]    raw_sel;
  logic [SCALED_W-1:0] scaled;
  logic [DIV_W-1:0]    rem_init, divisor;
  logic [SH_W-1:0]     sh_init, quo;
  logic [PROD_W-1:0]   prod_r;
  logic [DIV_W-1:0]    dw_r;

  assign raw_sel = (ctl.op == OP_HI) ? hi_raw : lo_raw;
  assign scaled  = SCALED_W'(raw_sel) * SCALED_W'(BOUND_SCALE);

  always_comb begin
    case (ctl.op)
      OP_LO, OP_HI: begin
        rem_init = DIV_W'(scaled >> STEPS_BOUND);
        sh_init  = {scaled[STEPS_BOUND-1:0], (SH_W - STEPS_BOUND)'(0)};
        divisor  = DIV_W'(BOUND_DIV);
      end
      OP_MEAN: begin
        rem_init = DIV_W'(sum_r >> SH_W);
        sh_init  = sum_r[SH_W-1:0];
        divisor  = DIV_W'(WINDOW);
      end
      OP_LVL: begin
        rem_init = prod_r[PROD_W-1:STEPS_LVL];
        sh_init  = {prod_r[STEPS_LVL-1:0], (SH_W - STEPS_LVL)'(0)};
        divisor  = dw_r;
      end
      default: begin
        rem_init = '0;
        sh_init  = '0;
        divisor  = '0;
      end
    endcase
  end

  tlas_div u_div (
    .clk      (clk),
    .ld       (ctl.ld),
    .step     (ctl.step),
    .rem_init (rem_init),
    .sh_init  (sh_init),
    .divisor  (divisor),
    .quo      (quo)
  );

  // quotient capture and level preparation
  logic [DIV_W-1:0]    lo_q_r, hi_q_r;
  logic [SAMPLE_W-1:0] mean_q_r;
  logic [LEVEL_W-1:0]  level_q_r;
  lvl_sel_t            lsel_r;
  logic [SAMPLE_W-1:0] clamp_v;
  logic [DIV_W-1:0]    diff;
  logic                below_lo;

  assign below_lo = (mean_q_r < SAMPLE_W'(lo_q_r));

  always_comb begin
    if (below_lo) begin
      clamp_v = SAMPLE_W'(lo_q_r);
    end else if (mean_q_r > SAMPLE_W'(hi_q_r)) begin
      clamp_v = SAMPLE_W'(hi_q_r);
    end else begin
      clamp_v = mean_q_r;
    end
  end

  assign diff = DIV_W'(clamp_v - SAMPLE_W'(lo_q_r));

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      case (ctl.op)
        OP_LO:   lo_q_r   <= quo[DIV_W-1:0];
        OP_HI:   hi_q_r   <= quo[DIV_W-1:0];
        OP_MEAN: mean_q_r <= quo;
        OP_LVL: begin
          case (lsel_r)
            LV_ZERO: level_q_r <= '0;
            LV_FULL: level_q_r <= LEVEL_W'(LEVEL_MAX);
            default: level_q_r <= quo[LEVEL_W-1:0];
          endcase
        end
        default: ;
      endcase
    end
    if (ctl.prep) begin
      prod_r <= PROD_W'({diff, 8'b0}) - PROD_W'(diff);
      dw_r   <= hi_q_r - lo_q_r;
      if (hi_q_r == lo_q_r) begin
        lsel_r <= LV_ZERO;
      end else if (lo_q_r > hi_q_r) begin
        // inverted window: clamps to either bound
        lsel_r <= below_lo ? LV_ZERO : LV_FULL;
      end else begin
        lsel_r <= LV_DIV;
      end
    end
    if (ctl.fin) begin
      level <= level_q_r;
      mean  <= mean_q_r;
    end
  end

endmodule

>>> design/tlas_ctrl.sv
module tlas_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           out_free,
  output tlas_pkg::ctl_t ctl
);
  import tlas_pkg::*;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_LO;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_RD;
      end
      ST_RD: begin
        op_nxt    = OP_LO;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        cnt_nxt   = op_steps(op_r);
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          case (op_r)
            OP_LO: begin
              op_nxt    = OP_HI;
              state_nxt = ST_LD;
            end
            OP_HI: begin
              op_nxt    = OP_MEAN;
              state_nxt = ST_LD;
            end
            OP_MEAN: state_nxt = ST_PREP;
            OP_LVL:  state_nxt = ST_DONE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PREP: begin
        op_nxt    = OP_LVL;
        state_nxt = ST_LD;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    ctl.accept = (state_r == ST_IDLE) && in_tvalid;
    ctl.upd    = (state_r == ST_RD);
    ctl.ld     = (state_r == ST_LD);
    ctl.step   = (state_r == ST_RUN) && (cnt_r != '0);
    ctl.cap    = (state_r == ST_RUN) && (cnt_r == '0);
    ctl.prep   = (state_r == ST_PREP);
    ctl.fin    = (state_r == ST_DONE) && out_free;
    ctl.op     = op_r;
  end

endmodule

>>> design/touch_level_average_and_scale_core.sv
// Two-channel touch level averager and scaler.
// Input stream (in_*): one transfer carries a 16-bit sample for channel A and D.
// Output stream (out_*): one transfer per input with the 16-bit truncated mean of
// the last WINDOW samples and an 8-bit level, the mean clamped into the
// calibration window and mapped linearly onto 0..255.
// Config port (cfg_*): cfg_addr 0..3 selects A low, A high, D low, D high raw
// bounds (10 bits); a bound is raw * 4000 / 1023. Write only while idle.
// Both lanes share one sequence of four bit-serial divisions (12, 12, 16 and
// 8 steps: lower bound, upper bound, mean, level) and take no new input until
// the result of the item reaches the output register. The next input is taken
// while a result still waits on out_*.
// Reset: config returns to 0 / 1023, the history reads as all zero, no result
// is pending. A stall on out_tready holds the result; the block then finishes
// at most one more item and waits with in_tready low.
module touch_level_average_and_scale_core #(
  parameter int WINDOW = tlas_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [tlas_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlas_pkg::RAW_W-1:0]      cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // sample_a[15:0], sample_d[31:16]
  // output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata   // level_a, level_d, mean_a, mean_d
);
  import tlas_pkg::*;

  // calibration registers
  logic [RAW_W-1:0] a_lo_r, a_hi_r, d_lo_r, d_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_lo_r <= '0;
      a_hi_r <= RAW_W'(BOUND_DIV);
      d_lo_r <= '0;
      d_hi_r <= RAW_W'(BOUND_DIV);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_A_LO: a_lo_r <= cfg_wdata;
        CFG_A_HI: a_hi_r <= cfg_wdata;
        CFG_D_LO: d_lo_r <= cfg_wdata;
        CFG_D_HI: d_hi_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // sequencer
  ctl_t ctl;
  logic out_valid_r;
  logic out_free;

  // result register is free when empty or being transferred this cycle
  assign out_free = !out_valid_r || out_tready;

  tlas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  // per-channel datapaths, run in lockstep
  logic [LEVEL_W-1:0]  level_a, level_d;
  logic [SAMPLE_W-1:0] mean_a, mean_d;

  tlas_lane #(.WINDOW(WINDOW)) u_lane_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_tdata[15:0]),
    .lo_raw (a_lo_r),
    .hi_raw (a_hi_r),
    .level  (level_a),
    .mean   (mean_a)
  );

  tlas_lane #(.WINDOW(WINDOW)) u_lane_d (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_tdata[31:16]),
    .lo_raw (d_lo_r),
    .hi_raw (d_hi_r),
    .level  (level_d),
    .mean   (mean_d)
  );

  // output valid: set when a result lands, cleared on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {mean_d, mean_a, level_d, level_a};

endmodule

>>> tb/tb_touch_level_average_and_scale_core.sv
`timescale 1ns / 1ps
module tb_touch_level_average_and_scale_core;
  import tlas_pkg::*;

  localparam int WIN             = WINDOW_DEF;
  // A stall this long means a hang.
  localparam int STALL_LIMIT     = 4000;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int NUM_PHASES      = 8;
  localparam int TAIL_CYCLES     = 80;

  // Field order is lowest bit last in a packed struct.
  typedef struct packed {
    logic [15:0] d;
    logic [15:0] a;
  } sample_t;

  typedef struct packed {
    logic [15:0] mean_d;
    logic [15:0] mean_a;
    logic [7:0]  level_d;
    logic [7:0]  level_a;
  } level_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [RAW_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [47:0]           out_tdata;

  // Predictor state: sample history, write slot and calibration registers.
  logic [15:0]           hist_a [WIN];
  logic [15:0]           hist_d [WIN];
  int                    slot = 0;
  logic [RAW_W-1:0]      bound_raw [4];

  sample_t               sample_queue [$];
  level_rec_t            expected_levels [$];
  int                    samples_queued = 0;
  int                    samples_taken = 0;
  int                    mismatches = 0;
  int                    idle_count = 0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  logic                  in_taken = 1'b0;
  level_rec_t            got_rec;
  level_rec_t            want_rec;

  always #10 clk = ~clk;

  touch_level_average_and_scale_core #(
    .WINDOW(WIN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // sample_a[15:0], sample_d[31:16]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)    // level_a[7:0], level_d[15:8], mean_a[31:16], mean_d[47:32]
  );

  // Calibration bound in sample counts: raw * 4000 / 1023, truncated.
  function automatic int bound_of(logic [RAW_W-1:0] raw);
    return int'(raw) * BOUND_SCALE / BOUND_DIV;
  endfunction

  // Clamp the mean into [lo, hi] and map onto 0..255.
  // An inverted window clamps below-lo to lo, everything else to hi.
  function automatic logic [7:0] scaled_level(logic [15:0] mean, logic [RAW_W-1:0] lo_raw,
                                              logic [RAW_W-1:0] hi_raw);
    int lo;
    int hi;
    int c;
    int v;
    lo = bound_of(lo_raw);
    hi = bound_of(hi_raw);
    if (int'(mean) < lo) c = lo;
    else if (int'(mean) > hi) c = hi;
    else c = int'(mean);
    if (hi == lo) return '0;   // zero-width window
    v = (c - lo) * LEVEL_MAX / (hi - lo);
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return v[7:0];
  endfunction

  // Write one sample into the history, re-sum both windows and queue the result.
  task automatic predict_levels(sample_t s);
    int         sum_a;
    int         sum_d;
    int         k;
    level_rec_t r;
    hist_a[slot] = s.a;
    hist_d[slot] = s.d;
    slot = (slot == WIN - 1) ? 0 : slot + 1;
    sum_a = 0;
    sum_d = 0;
    for (k = 0; k < WIN; k++) begin
      sum_a += int'(hist_a[k]);
      sum_d += int'(hist_d[k]);
    end
    r.mean_a  = 16'(sum_a / WIN);
    r.mean_d  = 16'(sum_d / WIN);
    r.level_a = scaled_level(r.mean_a, bound_raw[CFG_A_LO], bound_raw[CFG_A_HI]);
    r.level_d = scaled_level(r.mean_d, bound_raw[CFG_D_LO], bound_raw[CFG_D_HI]);
    expected_levels.push_back(r);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: hold the item until transfer, then maybe idle, then next item.
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= sample_queue.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random backpressure, none when the stall rate is zero.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check results against the oldest expectation, predict on each input transfer.
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_rec = out_tdata;
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want_rec = expected_levels.pop_front();
          check_field("level_a", want_rec.level_a, got_rec.level_a);
          check_field("level_d", want_rec.level_d, got_rec.level_d);
          check_field("mean_a", want_rec.mean_a, got_rec.mean_a);
          check_field("mean_d", want_rec.mean_d, got_rec.mean_d);
        end
      end
      if (in_tvalid && in_tready) begin
        predict_levels(in_tdata);
        samples_taken++;
      end
    end
  end

  // Watchdog: any transfer on either stream restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("tb_touch_level_average_and_scale_core failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic queue_sample(logic [15:0] a, logic [15:0] d);
    sample_t s;
    s.a = a;
    s.d = d;
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  task automatic write_bound(cfg_idx_t idx, logic [RAW_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    bound_raw[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_bounds(int a_lo, int a_hi, int d_lo, int d_hi);
    write_bound(CFG_A_LO, RAW_W'(a_lo));
    write_bound(CFG_A_HI, RAW_W'(a_hi));
    write_bound(CFG_D_LO, RAW_W'(d_lo));
    write_bound(CFG_D_HI, RAW_W'(d_hi));
  endtask

  // Block is idle once every queued sample went in and every result came out.
  task automatic wait_drained();
    while (samples_taken != samples_queued || expected_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Burst center: mostly the calibration range, its edges and the 16-bit extremes.
  function automatic int pick_target(logic [RAW_W-1:0] lo_raw, logic [RAW_W-1:0] hi_raw);
    int lo;
    int hi;
    int r;
    int j;
    lo = bound_of(lo_raw);
    hi = bound_of(hi_raw);
    r  = $urandom_range(99);
    if (r < 35) return $urandom_range(4100, 0);
    if (r < 55) begin
      j = $urandom_range(80);
      return ($urandom_range(1) ? lo : hi) + j - 40;
    end
    if (r < 75) return $urandom_range(65535, 0);
    if (r < 85) return $urandom_range(1) ? 65535 : 0;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [15:0] jitter(int target);
    int j;
    int v;
    j = $urandom_range(16);
    v = target + j - 8;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  initial begin
    int phase;
    int n;
    int k;
    int burst;
    int tgt_a;
    int tgt_d;
    for (k = 0; k < WIN; k++) begin
      hist_a[k] = '0;
      hist_d[k] = '0;
    end
    bound_raw[CFG_A_LO] = '0;
    bound_raw[CFG_A_HI] = '1;
    bound_raw[CFG_D_LO] = '0;
    bound_raw[CFG_D_HI] = '1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fill-up from zero history, full-scale saturation, crossed extremes,
    // alternating bit patterns and values at the top of the default window.
    @(posedge clk);
    queue_sample(16'h0000, 16'h0000);
    repeat (11) queue_sample(16'hFFFF, 16'hFFFF);
    queue_sample(16'h0000, 16'hFFFF);
    queue_sample(16'hFFFF, 16'h0000);
    queue_sample(16'h5555, 16'hAAAA);
    queue_sample(16'hAAAA, 16'h5555);
    queue_sample(16'd4000, 16'd3999);
    queue_sample(16'd1, 16'd1);
    queue_sample(16'd3910, 16'd3911);
    queue_sample(16'd2000, 16'd0);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1:       program_bounds(1023, 0, 600, 300);     // inverted windows
          2:       program_bounds(512, 512, 0, 0);        // zero-width windows
          3:       program_bounds(1023, 1023, 0, 1023);
          4:       program_bounds(0, 1, 1022, 1023);      // narrowest windows
          default: program_bounds($urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(1023), $urandom_range(1023));
        endcase
      end
      @(posedge clk);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // Bursts around a target let the mean settle near bounds and extremes.
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        burst = $urandom_range(15, 1);
        tgt_a = pick_target(bound_raw[CFG_A_LO], bound_raw[CFG_A_HI]);
        tgt_d = pick_target(bound_raw[CFG_D_LO], bound_raw[CFG_D_HI]);
        for (k = 0; k < burst && n < ITEMS_PER_PHASE; k++) begin
          queue_sample(jitter(tgt_a), jitter(tgt_d));
          n++;
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_touch_level_average_and_scale_core passed");
    end else begin
      $display("tb_touch_level_average_and_scale_core failed");
    end
    $finish;
  end

endmodule
